[rtl/core/hmhc_pkg.sv]
// ----------------------------------------------------------------------------
// hmhc_pkg
// Types and constants for the hotplate mode and heater controller.
// ----------------------------------------------------------------------------
package hmhc_pkg;

    typedef enum logic [1:0] {
        MODE_COOLING = 2'd0,
        MODE_EDITING = 2'd1,
        MODE_HEATING = 2'd2
    } mode_t;

    localparam logic [1:0] BTN_NONE        = 2'd0;
    localparam logic [1:0] BTN_CLICK       = 2'd1;
    localparam logic [1:0] BTN_LONG_REPEAT = 2'd2;

    localparam logic [2:0] CFG_SETPOINT_MAX  = 3'd0;
    localparam logic [2:0] CFG_SETPOINT_MIN  = 3'd1;
    localparam logic [2:0] CFG_FAN_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_HYSTERESIS    = 3'd3;
    localparam logic [2:0] CFG_FAN_FULL_DUTY = 3'd4;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] SETPOINT_MAX_RST  = 9'd250;
    localparam logic [8:0] SETPOINT_MIN_RST  = 9'd20;
    localparam logic [8:0] FAN_THRESHOLD_RST = 9'd40;
    localparam logic [3:0] HYSTERESIS_RST    = 4'd1;
    localparam logic [6:0] FAN_FULL_DUTY_RST = 7'd100;
    localparam logic [8:0] SETPOINT_RST      = 9'd20;

endpackage

[rtl/core/hotplate_mode_and_heater_control_top.sv]
// ----------------------------------------------------------------------------
// hotplate_mode_and_heater_control_top
// Bang-bang thermostat with a cooling / editing / heating mode and setpoint edit.
//
// Channel  Direction  Handshake          Payload
// s_axis   in         s_tvalid/s_tready  s_tdata, s_tuser (user event or sample)
// m_axis   out        m_tvalid/m_tready  m_tdata (state after the item)
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per clock while s_tready is high; its result is captured in the output register when the item transfers.
// State is updated in the cycle the item transfers, so items may follow back to back.
// s_tready drops only while a result is held and m_tready is low.
// rst_n clears mode, setpoint, heater, fan, m_tvalid and the config registers to their defaults; m_tdata is not reset.
// cfg_ready is always high; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module hotplate_mode_and_heater_control_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] button_event, [9:2] encoder_step, [19:10] plate_temp, [23:20] zero
    input  logic [hmhc_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] operation, [1] temp_valid
    input  logic [hmhc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] mode, [10:2] setpoint, [11] heater_on, [18:12] fan_duty,
    // [19] heat_indicator, [23:20] zero
    output logic [hmhc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hmhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hmhc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hmhc_pkg::*;

    logic [8:0]  setpoint_max_reg;
    logic [8:0]  setpoint_min_reg;
    logic [8:0]  fan_threshold_reg;
    logic [3:0]  hysteresis_reg;
    logic [6:0]  fan_full_duty_reg;

    mode_t       mode_reg, mode_next;
    logic [8:0]  setpoint_reg, setpoint_next;
    logic signed [7:0] prev_step_reg;
    logic        heater_reg, heater_next;
    logic [6:0]  fan_duty_reg, fan_duty_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic              in_op;
    logic              in_temp_valid;
    logic [1:0]        in_button;
    logic signed [7:0] in_step;
    logic signed [9:0] in_temp;

    logic signed [10:0] edit_diff;
    logic signed [10:0] edit_hi;
    logic signed [10:0] edit_val;
    logic signed [10:0] temp_ext;
    logic signed [10:0] temp_diff;
    logic signed [10:0] hyst_pos;
    logic signed [10:0] hyst_neg;
    logic               heater_after_off;
    logic               user_event;
    logic               sample_event;

    assign in_button     = s_tdata[1:0];
    assign in_step       = s_tdata[9:2];
    assign in_temp       = s_tdata[19:10];
    assign in_op         = s_tuser[0];
    assign in_temp_valid = s_tuser[1];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign user_event   = s_accept && !in_op;
    assign sample_event = s_accept && in_op && in_temp_valid;

    assign edit_diff = $signed({2'b00, setpoint_reg})
                       - $signed({{3{prev_step_reg[7]}}, prev_step_reg});
    assign edit_hi   = (edit_diff > $signed({2'b00, setpoint_max_reg}))
                       ? $signed({2'b00, setpoint_max_reg}) : edit_diff;
    assign edit_val  = (edit_hi < $signed({2'b00, setpoint_min_reg}))
                       ? $signed({2'b00, setpoint_min_reg}) : edit_hi;

    assign temp_ext  = $signed({in_temp[9], in_temp});
    assign temp_diff = temp_ext - $signed({2'b00, setpoint_reg});
    assign hyst_pos  = $signed({7'b0, hysteresis_reg});
    assign hyst_neg  = -hyst_pos;
    assign heater_after_off = heater_reg && !(temp_diff >= hyst_pos);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (user_event)
        begin
            case (in_button)
                BTN_CLICK:
                    mode_next = (mode_reg == MODE_EDITING) ? MODE_COOLING : MODE_EDITING;
                BTN_LONG_REPEAT:
                    mode_next = (mode_reg != MODE_HEATING) ? MODE_HEATING : MODE_COOLING;
                default:
                    mode_next = mode_reg;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        setpoint_next = setpoint_reg;
        heater_next   = heater_reg;
        fan_duty_next = fan_duty_reg;
        if (user_event && mode_reg == MODE_EDITING)
        begin
            setpoint_next = edit_val[8:0];
        end
        if (sample_event)
        begin
            case (mode_reg)
                MODE_HEATING:
                    heater_next = heater_after_off || (temp_diff <= hyst_neg);
                MODE_COOLING:
                    fan_duty_next = (temp_ext > $signed({2'b00, fan_threshold_reg}))
                                    ? fan_full_duty_reg : 7'd0;
                default:
                    heater_next = heater_reg;
            endcase
        end
        m_tdata_next = {4'b0, (mode_next == MODE_HEATING), fan_duty_next, heater_next,
                        setpoint_next, mode_next};
        m_tvalid_next = s_accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_max_reg  <= SETPOINT_MAX_RST;
            setpoint_min_reg  <= SETPOINT_MIN_RST;
            fan_threshold_reg <= FAN_THRESHOLD_RST;
            hysteresis_reg    <= HYSTERESIS_RST;
            fan_full_duty_reg <= FAN_FULL_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SETPOINT_MAX:  setpoint_max_reg  <= cfg_data;
                CFG_SETPOINT_MIN:  setpoint_min_reg  <= cfg_data;
                CFG_FAN_THRESHOLD: fan_threshold_reg <= cfg_data;
                CFG_HYSTERESIS:    hysteresis_reg    <= cfg_data[3:0];
                CFG_FAN_FULL_DUTY: fan_full_duty_reg <= cfg_data[6:0];
                default:           setpoint_max_reg  <= setpoint_max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_COOLING;
            setpoint_reg  <= SETPOINT_RST;
            prev_step_reg <= 8'sd0;
            heater_reg    <= 1'b0;
            fan_duty_reg  <= 7'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept)
            begin
                mode_reg     <= mode_next;
                setpoint_reg <= setpoint_next;
                heater_reg   <= heater_next;
                fan_duty_reg <= fan_duty_next;
                if (!in_op)
                begin
                    prev_step_reg <= in_step;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid_reg)
        else $error("transfer not followed by a result");

    a_setpoint_only_in_edit: assert property (@(posedge clk) disable iff (!rst_n)
        !(user_event && mode_reg == MODE_EDITING) |=> $stable(setpoint_reg))
        else $error("setpoint changed outside an edit");

    a_heater_only_in_heating: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_event && mode_reg == MODE_HEATING) |=> $stable(heater_reg))
        else $error("heater changed outside a heating sample");

    a_indicator_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[19] == (m_tdata_reg[1:0] == MODE_HEATING)))
        else $error("heat indicator disagrees with mode");

endmodule
